// ===== design/u8cu_pkg.sv =====
// shared types and constants for the utf-8 to code unit decoder
package u8cu_pkg;

    localparam logic [7:0]  LEAD_TWO_MIN   = 8'h80;
    localparam logic [7:0]  LEAD_THREE_MIN = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR_MIN  = 8'hF0;
    localparam logic [15:0] CP_UNSUPPORTED = 16'h003F;
    localparam logic [15:0] UNITS_SAT      = 16'hFFFF;
    localparam logic [15:0] MAX_UNITS_RST  = 16'hFFFF;
    localparam logic [1:0]  PEND_NONE      = 2'd0;
    localparam logic [1:0]  PEND_ONE       = 2'd1;
    localparam logic [1:0]  PEND_TWO       = 2'd2;

    typedef struct packed {
        logic [1:0]  pending;
        logic [15:0] partial;
        logic [15:0] units;
    } t_dec_state;

    typedef struct packed {
        logic        emit;
        logic [15:0] code_point;
    } t_dec_res;

endpackage

// ===== design/u8cu_if.sv =====
// byte input and code point output channel interfaces
interface u8cu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface u8cu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_point;
    logic        end_of_string;

    modport source (output valid, output code_point, output end_of_string, input ready);
    modport sink   (input valid, input code_point, input end_of_string, output ready);
endinterface

// ===== design/u8cu_dec.sv =====
// one byte decode step: next decoder state and optional code point
module u8cu_dec
    import u8cu_pkg::*;
(
    input  t_dec_state  i_state,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    input  logic [15:0] i_max_units,
    output t_dec_state  o_state,
    output t_dec_res    o_res
);

    logic [15:0] cont_bits;
    logic [15:0] merged;

    always_comb begin
        cont_bits = {10'b0, i_byte_value[5:0]};
        merged    = i_state.partial | ((i_state.pending == PEND_TWO) ? (cont_bits << 6)
                                                                       : cont_bits);
        o_state         = i_state;
        o_res.emit      = 1'b0;
        o_res.code_point = '0;

        if (i_state.pending != PEND_NONE) begin
            o_state.partial = merged;
            o_state.pending = i_state.pending - 2'd1;
            if (i_state.pending == PEND_ONE) begin
                o_res.emit       = 1'b1;
                o_res.code_point = merged;
            end
        end else if (i_state.units < i_max_units) begin
            if (i_byte_value < LEAD_TWO_MIN) begin
                o_res.emit       = 1'b1;
                o_res.code_point = {8'b0, i_byte_value};
            end else if (i_byte_value < LEAD_THREE_MIN) begin
                o_state.partial = {5'b0, i_byte_value[4:0], 6'b0};
                o_state.pending = PEND_ONE;
            end else if (i_byte_value < LEAD_FOUR_MIN) begin
                o_state.partial = {i_byte_value[3:0], 12'b0};
                o_state.pending = PEND_TWO;
            end else begin
                o_res.emit       = 1'b1;
                o_res.code_point = CP_UNSUPPORTED;
            end
        end

        if (o_res.emit) begin
            o_state.partial = '0;
            if (i_state.units != UNITS_SAT) begin
                o_state.units = i_state.units + 16'd1;
            end
        end

        // string boundary wipes all decoder state, finished or not
        if (i_last_byte) begin
            o_state.pending = PEND_NONE;
            o_state.partial = '0;
            o_state.units   = '0;
        end
    end

endmodule

// ===== design/utf8_to_code_unit_decoder.sv =====
// utf-8 byte stream to 16-bit code point decoder, top level
// path: input register, decode step, output register for each emitted code point
// throughput: one byte per cycle while the output register is not stalled
// a stalled output holds its beat while one more byte waits in the input register
// reset: synchronous active-low i_rst_n clears valids and decoder state, max_units to 65535
module utf8_to_code_unit_decoder
    import u8cu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    u8cu_in_if.sink           i_in,
    u8cu_out_if.source        o_out
);

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic [15:0] r_max_units;
    t_dec_state  r_state;
    t_dec_state  n_state;
    t_dec_res    dec_res;
    logic        r_out_vld;
    logic [15:0] r_out_cp;
    logic        r_out_eos;
    logic        advance;
    logic        in_take;

    assign advance   = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_in_vld || advance;
    assign in_take   = i_in.valid && i_in.ready;

    u8cu_dec u_dec (
        .i_state      (r_state),
        .i_byte_value (r_in_byte),
        .i_last_byte  (r_in_last),
        .i_max_units  (r_max_units),
        .o_state      (n_state),
        .o_res        (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= MAX_UNITS_RST;
        end else if (i_cfg_we) begin
            r_max_units <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in.byte_value;
            r_in_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (r_in_vld && advance) begin
            r_state <= n_state;
        end
    end

    // output register only fills when the byte completes a code point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld && dec_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld && dec_res.emit) begin
            r_out_cp  <= dec_res.code_point;
            r_out_eos <= r_in_last;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.code_point    = r_out_cp;
    assign o_out.end_of_string = r_out_eos;

endmodule
